@@ sv/bthin_pkg.sv @@
// Shared types, constants and the pixel deletion test for the thinning block.
package bthin_pkg;

    localparam int CFG_W = 10;

    typedef enum logic [0:0] {
        REG_FRAME_WIDTH  = 1'b0,
        REG_FRAME_HEIGHT = 1'b1
    } cfg_reg_t;

    localparam int NB_MIN = 2;
    localparam int NB_MAX = 6;

    typedef enum logic [1:0] {
        BK_PIXEL,
        BK_SWEEP,
        BK_TURN
    } back_state_t;

    // Neighbors are ordered N, NE, E, SE, S, SW, W, NW.
    function automatic logic thin_mark(input logic [7:0] n, input logic sub);
        logic [3:0] nb;
        logic [3:0] tr;
        logic       prod;
        nb = '0;
        tr = '0;
        for (int i = 0; i < 8; i++) begin
            nb = nb + 4'(n[i]);
            if (!n[i] && n[(i + 1) % 8])
            begin
                tr = tr + 4'd1;
            end
        end
        if (!sub)
        begin
            prod = (n[0] & n[2] & n[4]) | (n[2] & n[4] & n[6]);
        end
        else
        begin
            prod = (n[0] & n[2] & n[6]) | (n[0] & n[4] & n[6]);
        end
        return (nb >= 4'(NB_MIN)) && (nb <= 4'(NB_MAX)) && (tr == 4'd1) && !prod;
    endfunction

endpackage

@@ sv/bthin_in_if.sv @@
// Input pixel channel with valid/ready handshake.
interface bthin_in_if;
    logic valid;
    logic ready;
    logic pixel_on;

    modport source (output valid, output pixel_on, input ready);
    modport sink (input valid, input pixel_on, output ready);
endinterface

@@ sv/bthin_out_if.sv @@
// Output pixel channel with valid/ready handshake.
interface bthin_out_if;
    logic valid;
    logic ready;
    logic thin_pixel;
    logic frame_last;

    modport source (output valid, output thin_pixel, output frame_last, input ready);
    modport sink (input valid, input thin_pixel, input frame_last, output ready);
endinterface

@@ sv/bthin_front.sv @@
// Front end: accepts pixels and assigns each its raster position and end-of-frame flag.
module bthin_front
    import bthin_pkg::*;
#(
    parameter int IDX_W = 18
)
(
    input  logic             clk,
    input  logic             rst_n,
    bthin_in_if.sink         pix_in,
    input  logic [IDX_W:0]   total,
    input  logic             q_ready,
    output logic             q_push,
    output logic [IDX_W-1:0] q_pos,
    output logic             q_pixel,
    output logic             q_last
);

    logic [IDX_W-1:0] pos_reg;
    logic [IDX_W-1:0] pos_next;
    logic [IDX_W-1:0] pos_use;

    always_comb
    begin
        pos_use = ({1'b0, pos_reg} >= total) ? '0 : pos_reg;
        q_last  = ({1'b0, pos_use} == (total - 1'b1));
        q_pos   = pos_use;
        q_pixel = pix_in.pixel_on;
        q_push  = pix_in.valid && q_ready;
        pix_in.ready = q_ready;
        if (q_push)
        begin
            pos_next = q_last ? '0 : pos_use + 1'b1;
        end
        else
        begin
            pos_next = pos_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pos_reg <= '0;
        end
        else
        begin
            pos_reg <= pos_next;
        end
    end

endmodule

@@ sv/bthin_queue.sv @@
// Short request queue between the front end and the thinning engine.
module bthin_queue
    import bthin_pkg::*;
#(
    parameter int WIDTH = 20
)
(
    input  logic             clk,
    input  logic             rst_n,
    input  logic             push,
    input  logic [WIDTH-1:0] push_data,
    output logic             not_full,
    input  logic             pop,
    output logic             not_empty,
    output logic [WIDTH-1:0] pop_data
);

    logic [WIDTH-1:0] slot_reg [4];
    logic [1:0]       wr_ptr_reg;
    logic [1:0]       wr_ptr_next;
    logic [1:0]       rd_ptr_reg;
    logic [1:0]       rd_ptr_next;
    logic [2:0]       count_reg;
    logic [2:0]       count_next;

    always_comb
    begin
        not_full    = (count_reg != 3'd4);
        not_empty   = (count_reg != 3'd0);
        pop_data    = slot_reg[rd_ptr_reg];
        wr_ptr_next = push ? wr_ptr_reg + 2'd1 : wr_ptr_reg;
        rd_ptr_next = pop ? rd_ptr_reg + 2'd1 : rd_ptr_reg;
        count_next  = count_reg + 3'(push) - 3'(pop);
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            slot_reg[wr_ptr_reg] <= push_data;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

endmodule

@@ sv/bthin_back.sv @@
// Back end: frame stores, pixel read-out and the Zhang-Suen thinning sweep engine.
module bthin_back
    import bthin_pkg::*;
#(
    parameter int MAX_WIDTH  = 512,
    parameter int MAX_HEIGHT = 512
)
(
    input  logic                                   clk,
    input  logic                                   rst_n,
    input  logic [$clog2(MAX_WIDTH+1)-1:0]         width,
    input  logic [$clog2(MAX_HEIGHT+1)-1:0]        height,
    input  logic [$clog2(MAX_WIDTH*MAX_HEIGHT):0]  total,
    input  logic                                   q_valid,
    input  logic [$clog2(MAX_WIDTH*MAX_HEIGHT)-1:0] q_pos,
    input  logic                                   q_pixel,
    input  logic                                   q_last,
    output logic                                   q_pop,
    bthin_out_if.source                            pix_out
);

    localparam int DEPTH = MAX_WIDTH * MAX_HEIGHT;
    localparam int IDX_W = $clog2(DEPTH);
    localparam int TOT_W = IDX_W + 1;
    localparam int DIM_W = $clog2(MAX_WIDTH + 1);
    localparam int HT_W  = $clog2(MAX_HEIGHT + 1);
    localparam int COL_W = $clog2(MAX_WIDTH);
    localparam int ROW_W = $clog2(MAX_HEIGHT);

    logic             load_mem [DEPTH];
    logic             thin_mem [DEPTH];
    logic [1:0]       line_mem [MAX_WIDTH];

    back_state_t      state_reg;
    back_state_t      state_next;

    logic             load_rd_reg;
    logic             thin_rd_reg;
    logic [1:0]       line_rd_reg;

    logic             pend_reg;
    logic             pend_last_reg;
    logic             pend_hit_reg;
    logic             ov_reg;
    logic             out_pix_reg;
    logic             out_last_reg;
    logic [TOT_W-1:0] fill_reg;

    logic             sub_reg;
    logic             from_load_reg;
    logic             any_reg;
    logic [TOT_W-1:0] ridx_reg;
    logic [COL_W-1:0] rx_reg;
    logic             issued_all_reg;
    logic             s1_v_reg;
    logic             s1_zero_reg;
    logic             s1_c_reg;
    logic [COL_W-1:0] s1_col_reg;
    logic             s2_v_reg;
    logic             s2_c_reg;
    logic [2:0]       win_a_reg;
    logic [2:0]       win_b_reg;
    logic [2:0]       win_c_reg;
    logic [COL_W-1:0] cx_reg;
    logic [ROW_W-1:0] cy_reg;
    logic [IDX_W-1:0] cidx_reg;

    logic             issue;
    logic             start;
    logic             cen_en;
    logic             cen_done;
    logic             interior;
    logic             del;
    logic             s1_pix;
    logic [7:0]       nbr;
    logic [TOT_W-1:0] end_r;
    logic             thin_rd_en;
    logic [IDX_W-1:0] thin_rd_addr;

    always_comb
    begin
        end_r    = total + TOT_W'(width);
        cen_en   = s2_v_reg && s2_c_reg;
        cen_done = cen_en && ({1'b0, cidx_reg} == (total - 1'b1));
        interior = (cx_reg != '0) && (cy_reg != '0)
                   && ((DIM_W+1)'(cx_reg) + (DIM_W+1)'(2) <= (DIM_W+1)'(width))
                   && ((HT_W+1)'(cy_reg) + (HT_W+1)'(2) <= (HT_W+1)'(height));
        nbr = {win_c_reg[2], win_b_reg[2], win_a_reg[2], win_a_reg[1],
               win_a_reg[0], win_b_reg[0], win_c_reg[0], win_c_reg[1]};
        del    = interior && win_b_reg[1] && thin_mark(nbr, sub_reg);
        s1_pix = s1_zero_reg ? 1'b0 : (from_load_reg ? load_rd_reg : thin_rd_reg);
    end

    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            BK_PIXEL:
            begin
                if (q_pop && q_last)
                begin
                    state_next = BK_SWEEP;
                end
            end
            BK_SWEEP:
            begin
                if (cen_done)
                begin
                    state_next = BK_TURN;
                end
            end
            BK_TURN:
            begin
                state_next = (!sub_reg || any_reg) ? BK_SWEEP : BK_PIXEL;
            end
            default:
            begin
                state_next = BK_PIXEL;
            end
        endcase
    end

    always_comb
    begin
        q_pop = 1'b0;
        issue = 1'b0;
        case (state_reg)
            BK_PIXEL:
            begin
                q_pop = q_valid && !pend_reg && (!ov_reg || pix_out.ready);
            end
            BK_SWEEP:
            begin
                issue = !issued_all_reg;
            end
            default:
            begin
                q_pop = 1'b0;
            end
        endcase
        start        = (state_reg != BK_SWEEP) && (state_next == BK_SWEEP);
        thin_rd_en   = q_pop || (issue && !from_load_reg);
        thin_rd_addr = q_pop ? q_pos : ridx_reg[IDX_W-1:0];
        pix_out.valid      = ov_reg;
        pix_out.thin_pixel = out_pix_reg;
        pix_out.frame_last = out_last_reg;
    end

    always_ff @(posedge clk)
    begin
        if (q_pop)
        begin
            load_mem[q_pos] <= q_pixel;
        end
        if (issue && from_load_reg)
        begin
            load_rd_reg <= load_mem[ridx_reg[IDX_W-1:0]];
        end
    end

    always_ff @(posedge clk)
    begin
        if (cen_en)
        begin
            thin_mem[cidx_reg] <= win_b_reg[1] & ~del;
        end
        if (thin_rd_en)
        begin
            thin_rd_reg <= thin_mem[thin_rd_addr];
        end
    end

    // With a one-pixel row the column being written is the one read next, so forward it.
    always_ff @(posedge clk)
    begin
        if (s1_v_reg)
        begin
            line_mem[s1_col_reg] <= {line_rd_reg[0], s1_pix};
        end
        if (issue)
        begin
            if (s1_v_reg && (s1_col_reg == rx_reg))
            begin
                line_rd_reg <= {line_rd_reg[0], s1_pix};
            end
            else
            begin
                line_rd_reg <= line_mem[rx_reg];
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (s1_v_reg)
        begin
            win_a_reg <= {win_a_reg[1:0], s1_pix};
            win_b_reg <= {win_b_reg[1:0], line_rd_reg[0]};
            win_c_reg <= {win_c_reg[1:0], line_rd_reg[1]};
        end
        if (pend_reg)
        begin
            out_pix_reg  <= pend_hit_reg & thin_rd_reg;
            out_last_reg <= pend_last_reg;
        end
        if (q_pop)
        begin
            pend_last_reg <= q_last;
            pend_hit_reg  <= ({1'b0, q_pos} < fill_reg);
        end
        s1_zero_reg <= (ridx_reg >= total);
        s1_c_reg    <= (ridx_reg >= TOT_W'(width) + 1'b1);
        s1_col_reg  <= rx_reg;
        s2_c_reg    <= s1_c_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= BK_PIXEL;
            pend_reg       <= 1'b0;
            ov_reg         <= 1'b0;
            fill_reg       <= '0;
            sub_reg        <= 1'b0;
            from_load_reg  <= 1'b0;
            any_reg        <= 1'b0;
            ridx_reg       <= '0;
            rx_reg         <= '0;
            issued_all_reg <= 1'b1;
            s1_v_reg       <= 1'b0;
            s2_v_reg       <= 1'b0;
            cx_reg         <= '0;
            cy_reg         <= '0;
            cidx_reg       <= '0;
        end
        else
        begin
            state_reg <= state_next;
            pend_reg  <= q_pop;
            if (pend_reg)
            begin
                ov_reg <= 1'b1;
            end
            else if (pix_out.ready)
            begin
                ov_reg <= 1'b0;
            end
            s1_v_reg <= issue;
            s2_v_reg <= s1_v_reg;
            if (start)
            begin
                ridx_reg       <= '0;
                rx_reg         <= '0;
                issued_all_reg <= 1'b0;
                cx_reg         <= '0;
                cy_reg         <= '0;
                cidx_reg       <= '0;
                if (state_reg == BK_PIXEL)
                begin
                    sub_reg       <= 1'b0;
                    from_load_reg <= 1'b1;
                    any_reg       <= 1'b0;
                    if (total > fill_reg)
                    begin
                        fill_reg <= total;
                    end
                end
                else
                begin
                    sub_reg       <= !sub_reg;
                    from_load_reg <= 1'b0;
                    if (sub_reg)
                    begin
                        any_reg <= 1'b0;
                    end
                end
            end
            else
            begin
                if (issue)
                begin
                    ridx_reg       <= ridx_reg + 1'b1;
                    rx_reg         <= ((DIM_W+1)'(rx_reg) + 1'b1 == (DIM_W+1)'(width))
                                      ? '0 : rx_reg + 1'b1;
                    issued_all_reg <= (ridx_reg == end_r);
                end
                if (cen_en)
                begin
                    cidx_reg <= cidx_reg + 1'b1;
                    any_reg  <= any_reg | del;
                    if ((DIM_W+1)'(cx_reg) + 1'b1 == (DIM_W+1)'(width))
                    begin
                        cx_reg <= '0;
                        cy_reg <= cy_reg + 1'b1;
                    end
                    else
                    begin
                        cx_reg <= cx_reg + 1'b1;
                    end
                end
            end
        end
    end

endmodule

@@ sv/binary_image_thinning.sv @@
// Top level of the binary image thinning block: configuration registers and the two ends.
//
// Pixels arrive in raster order and each returns the thinned pixel of the previous frame at
// the same position, so the first frame reads zeros. The back end takes a new pixel only once
// the previous pixel's stored result has been read. On a frame's last pixel the engine thins
// the stored frame: every subiteration is one raster sweep of the frame store followed by a
// turn state, two sweeps per Zhang-Suen iteration, repeated until an iteration deletes
// nothing, and new pixels queue (four deep) and then stall meanwhile. The first sweep reads
// the load store directly, so no separate copy pass exists. The thinned store carries a fill
// count rather than a clearing pass, so the block is ready at reset. A frame size write is in
// force from the next cycle.
// Frame size registers may only be written while the block is idle.
module binary_image_thinning
    import bthin_pkg::*;
#(
    parameter int MAX_WIDTH  = 512,
    parameter int MAX_HEIGHT = 512
)
(
    input  logic             clk,
    input  logic             rst_n,
    input  logic             cfg_wr_en,
    input  logic             cfg_index,
    input  logic [CFG_W-1:0] cfg_wr_data,
    bthin_in_if.sink         pix_in,
    bthin_out_if.source      pix_out
);

    localparam int IDX_W = $clog2(MAX_WIDTH * MAX_HEIGHT);
    localparam int DIM_W = $clog2(MAX_WIDTH + 1);
    localparam int HT_W  = $clog2(MAX_HEIGHT + 1);
    localparam int CWW   = (CFG_W > DIM_W) ? CFG_W : DIM_W;
    localparam int CWH   = (CFG_W > HT_W) ? CFG_W : HT_W;
    localparam int RST_W = (MAX_WIDTH < 512) ? MAX_WIDTH : 512;
    localparam int RST_H = (MAX_HEIGHT < 512) ? MAX_HEIGHT : 512;
    localparam int Q_W   = IDX_W + 2;

    logic [DIM_W-1:0] w_reg;
    logic [DIM_W-1:0] w_next;
    logic [HT_W-1:0]  h_reg;
    logic [HT_W-1:0]  h_next;
    logic [IDX_W:0]   total_reg;
    logic [IDX_W:0]   total_next;

    logic             q_push;
    logic             q_ready;
    logic             q_valid;
    logic             q_pop;
    logic [IDX_W-1:0] f_pos;
    logic             f_pixel;
    logic             f_last;
    logic [Q_W-1:0]   q_out;

    always_comb
    begin
        w_next = w_reg;
        h_next = h_reg;
        if (cfg_wr_en && (cfg_index == REG_FRAME_WIDTH))
        begin
            if (CWW'(cfg_wr_data) == '0)
            begin
                w_next = DIM_W'(1);
            end
            else if (CWW'(cfg_wr_data) > CWW'(MAX_WIDTH))
            begin
                w_next = DIM_W'(MAX_WIDTH);
            end
            else
            begin
                w_next = DIM_W'(cfg_wr_data);
            end
        end
        if (cfg_wr_en && (cfg_index == REG_FRAME_HEIGHT))
        begin
            if (CWH'(cfg_wr_data) == '0)
            begin
                h_next = HT_W'(1);
            end
            else if (CWH'(cfg_wr_data) > CWH'(MAX_HEIGHT))
            begin
                h_next = HT_W'(MAX_HEIGHT);
            end
            else
            begin
                h_next = HT_W'(cfg_wr_data);
            end
        end
        total_next = (IDX_W+1)'(w_next) * (IDX_W+1)'(h_next);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            w_reg     <= DIM_W'(RST_W);
            h_reg     <= HT_W'(RST_H);
            total_reg <= (IDX_W+1)'(RST_W * RST_H);
        end
        else
        begin
            w_reg     <= w_next;
            h_reg     <= h_next;
            total_reg <= total_next;
        end
    end

    bthin_front #(
        .IDX_W (IDX_W)
    ) u_front (
        .clk     (clk),
        .rst_n   (rst_n),
        .pix_in  (pix_in),
        .total   (total_reg),
        .q_ready (q_ready),
        .q_push  (q_push),
        .q_pos   (f_pos),
        .q_pixel (f_pixel),
        .q_last  (f_last)
    );

    bthin_queue #(
        .WIDTH (Q_W)
    ) u_queue (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (q_push),
        .push_data ({f_pos, f_pixel, f_last}),
        .not_full  (q_ready),
        .pop       (q_pop),
        .not_empty (q_valid),
        .pop_data  (q_out)
    );

    bthin_back #(
        .MAX_WIDTH  (MAX_WIDTH),
        .MAX_HEIGHT (MAX_HEIGHT)
    ) u_back (
        .clk     (clk),
        .rst_n   (rst_n),
        .width   (w_reg),
        .height  (h_reg),
        .total   (total_reg),
        .q_valid (q_valid),
        .q_pos   (q_out[Q_W-1:2]),
        .q_pixel (q_out[1]),
        .q_last  (q_out[0]),
        .q_pop   (q_pop),
        .pix_out (pix_out)
    );

endmodule

@@ sv/bthin_checker.sv @@
// Port-level checker for the thinning block and its bind to the top level.
module bthin_checker
(
    input logic clk,
    input logic rst_n,
    input logic in_valid,
    input logic in_ready,
    input logic out_valid,
    input logic out_ready,
    input logic out_pixel,
    input logic out_last
);

    logic [3:0] count_reg;
    logic       in_acc;
    logic       out_acc;

    assign in_acc  = in_valid && in_ready;
    assign out_acc = out_valid && out_ready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg <= '0;
        end
        else
        begin
            count_reg <= count_reg + 4'(in_acc) - 4'(out_acc);
        end
    end

    // A stalled result request keeps its value.
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid && $stable(out_pixel) && $stable(out_last))
        else $error("output request changed while stalled");

    // Every result request follows an accepted pixel that has no result yet.
    a_no_invent: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> count_reg != 4'd0)
        else $error("result without an outstanding pixel");

    // The queue and the output stage bound the pixels in flight.
    a_bounded: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= 4'd6)
        else $error("too many pixels in flight");

endmodule

bind binary_image_thinning bthin_checker u_checker (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (pix_in.valid),
    .in_ready  (pix_in.ready),
    .out_valid (pix_out.valid),
    .out_ready (pix_out.ready),
    .out_pixel (pix_out.thin_pixel),
    .out_last  (pix_out.frame_last)
);
